>>> design/ttlc_pkg.sv
// Shared constants, command and register codes, controller state and the
// control bundle of the TTL cache table.
// No dependencies; every other design file imports this package.
package ttlc_pkg;

    // Table geometry
    localparam int CAPACITY     = 64;
    localparam int KEY_W        = 32;
    localparam int TIME_W       = 32;
    localparam int CNT_W        = $clog2(CAPACITY + 1);

    // Field widths on the ports
    localparam int CMD_W        = 2;
    localparam int OCC_W        = 7;
    localparam int TTL_W        = 20;
    localparam int PERIOD_W     = 16;
    localparam int CFG_DATA_W   = 20;
    localparam int CFG_IDX_W    = 1;

    // Register reset values
    localparam int TTL_RESET    = 1000;
    localparam int PERIOD_RESET = 1;

    // Occupancy count: groups of valid bits counted first, then summed
    localparam int GRP_W        = 8;
    localparam int NUM_GRP      = (CAPACITY + GRP_W - 1) / GRP_W;
    localparam int PAD_W        = NUM_GRP * GRP_W;
    localparam int GRP_CNT_W    = $clog2(GRP_W + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_STORE  = 2'd2,
        CMD_FLUSH  = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TTL    = 1'b0,
        CFG_PERIOD = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_APPLY,
        ST_COUNT,
        ST_SUM
    } t_state;

    // Controller to datapath strobes
    typedef struct packed {
        logic accept;
        logic compare;
        logic apply;
        logic count;
        logic load;
    } t_dp_ctl;

endpackage

>>> design/ttlc_in_if.sv
// Command channel of the TTL cache table: valid/ready plus command and key.
// Depends on ttlc_pkg for the field widths.
interface ttlc_in_if;
    import ttlc_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key;

    modport source (output valid, output command, output key, input ready);
    modport sink   (input valid, input command, input key, output ready);
endinterface

>>> design/ttlc_out_if.sv
// Result channel of the TTL cache table: valid/ready plus result flags and counts.
// Depends on ttlc_pkg for the field widths.
interface ttlc_out_if;
    import ttlc_pkg::*;

    logic             valid;
    logic             ready;
    logic             hit;
    logic             inserted;
    logic             dropped_full;
    logic [OCC_W-1:0] occupancy;
    logic [OCC_W-1:0] peak_occupancy;

    modport source (output valid, output hit, output inserted, output dropped_full,
                    output occupancy, output peak_occupancy, input ready);
    modport sink   (input valid, input hit, input inserted, input dropped_full,
                    input occupancy, input peak_occupancy, output ready);
endinterface

>>> design/ttl_cache_table_core.sv
// TTL cache table: a fully associative table of ttlc_pkg::CAPACITY keys, each
// with an expiry time, driven by tick, lookup, store and flush commands. Every
// command beat yields one result beat with the hit/inserted/dropped flags and
// the occupancy after the command plus its peak since reset. One command is in
// work at a time. After the accepting edge it passes in order through tag and
// expiry compare over all entries, table update, group count of the valid bits,
// and the occupancy sum with result load; the load waits while the last result
// is not yet taken. A new command is taken the cycle after the load and not
// before, so commands never overlap. Times compare as signed differences
// modulo 2^32.
// The user must write configuration (ttl_ticks at index 0, check_period at
// index 1) only while no command is in work; the block itself does not enforce
// this. Depends on ttlc_pkg, ttlc_in_if, ttlc_out_if, ttlc_ctrl and ttlc_dp.
module ttl_cache_table_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ttlc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ttlc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ttlc_in_if.sink                         i_req,
    ttlc_out_if.source                      o_rsp
);
    import ttlc_pkg::*;

    t_dp_ctl w_ctl;

    // Sequencer
    ttlc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_ctl       (w_ctl)
    );

    // Table and counters
    ttlc_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (w_ctl),
        .i_command        (i_req.command),
        .i_key            (i_req.key),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_hit            (o_rsp.hit),
        .o_inserted       (o_rsp.inserted),
        .o_dropped_full   (o_rsp.dropped_full),
        .o_occupancy      (o_rsp.occupancy),
        .o_peak_occupancy (o_rsp.peak_occupancy)
    );

endmodule

>>> design/ttlc_ctrl.sv
// Sequencer of the TTL cache table: walks one beat through compare, apply,
// count and result load, and owns the result valid flag. Depends on ttlc_pkg.
module ttlc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output ttlc_pkg::t_dp_ctl o_ctl
);
    import ttlc_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_load;

    // Result slot free when empty or being drained this cycle
    assign w_load = (r_state == ST_SUM) && (!r_out_valid || i_rsp_ready);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_req_valid) n_state = ST_CMP;
            ST_CMP:   n_state = ST_APPLY;
            ST_APPLY: n_state = ST_COUNT;
            ST_COUNT: n_state = ST_SUM;
            ST_SUM:   if (w_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Strobes to the datapath
    always_comb begin
        o_req_ready   = 1'b0;
        o_ctl         = '0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready  = 1'b1;
                o_ctl.accept = i_req_valid;
            end
            ST_CMP:   o_ctl.compare = 1'b1;
            ST_APPLY: o_ctl.apply   = 1'b1;
            ST_COUNT: o_ctl.count   = 1'b1;
            ST_SUM:   o_ctl.load    = w_load;
            default: ;
        endcase
    end

    // Result valid: set on load, cleared when the beat is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_rsp_ready) n_out_valid = 1'b0;
        if (w_load)                     n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_rsp_valid = r_out_valid;

    // A result only appears out of the load state
    a_rsp_from_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_SUM))
        else $error("result valid rose outside load state");

endmodule

>>> design/ttlc_dp.sv
// Datapath of the TTL cache table: entry registers, parallel key and expiry
// compare, table update, time and sweep counters, occupancy count, config
// registers and result register. Depends on ttlc_pkg.
module ttlc_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ttlc_pkg::t_dp_ctl           i_ctl,
    input  logic [ttlc_pkg::CMD_W-1:0]  i_command,
    input  logic [ttlc_pkg::KEY_W-1:0]  i_key,
    input  logic                        i_cfg_we,
    input  logic [ttlc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ttlc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                        o_hit,
    output logic                        o_inserted,
    output logic                        o_dropped_full,
    output logic [ttlc_pkg::OCC_W-1:0]  o_occupancy,
    output logic [ttlc_pkg::OCC_W-1:0]  o_peak_occupancy
);
    import ttlc_pkg::*;

    // Entry storage, one row of cells compared in parallel
    logic [KEY_W-1:0]    r_key_arr [CAPACITY];
    logic [TIME_W-1:0]   r_exp_arr [CAPACITY];
    logic [CAPACITY-1:0] r_valid, n_valid;

    // Control state
    logic [TIME_W-1:0]   r_now;
    logic [PERIOD_W-1:0] r_sweep_cnt, n_sweep_cnt;
    logic [TTL_W-1:0]    r_ttl;
    logic [PERIOD_W-1:0] r_period;
    logic [CNT_W-1:0]    r_held, n_held;
    logic [CNT_W-1:0]    r_peak, n_peak;

    // Beat in flight
    t_cmd                r_cmd;
    logic [KEY_W-1:0]    r_key;
    logic                r_sweep;
    logic [CAPACITY-1:0] r_match, n_match;
    logic [CAPACITY-1:0] r_exp, n_exp;
    logic [TIME_W-1:0]   n_diff [CAPACITY];
    logic                r_hit, n_hit;
    logic                r_ins, n_ins;
    logic                r_drop, n_drop;
    logic                n_renew;
    logic [GRP_CNT_W-1:0] r_grp [NUM_GRP];
    logic [GRP_CNT_W-1:0] n_grp [NUM_GRP];

    // Result register
    logic                r_out_hit, r_out_ins, r_out_drop;
    logic [CNT_W-1:0]    r_out_occ, r_out_peak;

    logic [TIME_W-1:0]   n_expiry;
    logic [CAPACITY-1:0] n_free_oh;
    logic                n_full;
    logic                n_any_match;
    logic                n_match_exp;
    logic [PAD_W-1:0]    n_valid_pad;

    // Tag compare and modular expiry test, one per entry
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_diff[i]  = r_now - r_exp_arr[i];
            n_match[i] = r_valid[i] && (r_key_arr[i] == r_key);
            n_exp[i]   = r_valid[i] && (n_diff[i] != '0) && !n_diff[i][TIME_W-1];
        end
    end

    // Shared terms of the update
    assign n_sweep_cnt = r_sweep_cnt + PERIOD_W'(1);
    assign n_expiry    = r_now + TIME_W'(r_ttl);
    assign n_free_oh   = ~r_valid & (r_valid + CAPACITY'(1));
    assign n_full      = &r_valid;
    assign n_any_match = |r_match;
    assign n_match_exp = |(r_match & r_exp);

    // Table update per command
    always_comb begin
        n_valid = r_valid;
        n_hit   = 1'b0;
        n_ins   = 1'b0;
        n_drop  = 1'b0;
        n_renew = 1'b0;
        case (r_cmd)
            CMD_TICK: begin
                if (r_sweep) n_valid = r_valid & ~r_exp;
            end
            CMD_LOOKUP: begin
                if (n_any_match) begin
                    if (n_match_exp) begin
                        n_valid = r_valid & ~r_match;
                    end else begin
                        n_hit   = 1'b1;
                        n_renew = 1'b1;
                    end
                end
            end
            CMD_STORE: begin
                if (!n_any_match) begin
                    if (n_full) begin
                        n_drop = 1'b1;
                    end else begin
                        n_valid = r_valid | n_free_oh;
                        n_ins   = 1'b1;
                    end
                end
            end
            CMD_FLUSH: n_valid = '0;
            default: ;
        endcase
    end

    // Occupancy: count groups of valid bits, then add the groups
    assign n_valid_pad = PAD_W'(r_valid);

    always_comb begin
        for (int g = 0; g < NUM_GRP; g++) begin
            n_grp[g] = '0;
            for (int b = 0; b < GRP_W; b++) begin
                n_grp[g] = n_grp[g] + GRP_CNT_W'(n_valid_pad[g*GRP_W + b]);
            end
        end
    end

    always_comb begin
        n_held = '0;
        for (int g = 0; g < NUM_GRP; g++) begin
            n_held = n_held + CNT_W'(r_grp[g]);
        end
        n_peak = (n_held > r_peak) ? n_held : r_peak;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_now       <= '0;
            r_sweep_cnt <= '0;
            r_ttl       <= TTL_W'(TTL_RESET);
            r_period    <= PERIOD_W'(PERIOD_RESET);
            r_held      <= '0;
            r_peak      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_TTL:    r_ttl    <= i_cfg_data[TTL_W-1:0];
                    CFG_PERIOD: r_period <= i_cfg_data[PERIOD_W-1:0];
                    default: ;
                endcase
            end
            // Tick advances time at accept; the sweep runs on the new time
            if (i_ctl.accept && (t_cmd'(i_command) == CMD_TICK)) begin
                r_now <= r_now + TIME_W'(1);
                if (n_sweep_cnt >= r_period) r_sweep_cnt <= '0;
                else                         r_sweep_cnt <= n_sweep_cnt;
            end
            if (i_ctl.apply) r_valid <= n_valid;
            if (i_ctl.load) begin
                r_held <= n_held;
                r_peak <= n_peak;
            end
        end
    end

    // Beat payload and entry contents
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd   <= t_cmd'(i_command);
            r_key   <= i_key;
            r_sweep <= (t_cmd'(i_command) == CMD_TICK) && (n_sweep_cnt >= r_period);
        end
        if (i_ctl.compare) begin
            r_match <= n_match;
            r_exp   <= n_exp;
        end
        if (i_ctl.apply) begin
            r_hit  <= n_hit;
            r_ins  <= n_ins;
            r_drop <= n_drop;
            for (int i = 0; i < CAPACITY; i++) begin
                if (n_renew && r_match[i]) r_exp_arr[i] <= n_expiry;
                if (n_ins && n_free_oh[i]) begin
                    r_key_arr[i] <= r_key;
                    r_exp_arr[i] <= n_expiry;
                end
            end
        end
        if (i_ctl.count) begin
            for (int g = 0; g < NUM_GRP; g++) r_grp[g] <= n_grp[g];
        end
        if (i_ctl.load) begin
            r_out_hit  <= r_hit;
            r_out_ins  <= r_ins;
            r_out_drop <= r_drop;
            r_out_occ  <= n_held;
            r_out_peak <= n_peak;
        end
    end

    assign o_hit            = r_out_hit;
    assign o_inserted       = r_out_ins;
    assign o_dropped_full   = r_out_drop;
    assign o_occupancy      = OCC_W'(r_out_occ);
    assign o_peak_occupancy = OCC_W'(r_out_peak);

    // Keys held are unique, so a lookup or store matches one entry at most
    a_match_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.apply && ((r_cmd == CMD_LOOKUP) || (r_cmd == CMD_STORE))
        |-> $onehot0(r_match))
        else $error("key held in more than one entry");

    a_peak_ge_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak >= r_held)
        else $error("peak occupancy below occupancy");

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_flag_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.apply |=> $onehot0({r_hit, r_ins, r_drop}))
        else $error("more than one result flag set");

endmodule

>>> tb/ttl_cache_table_core_tb.sv
// Self-checking testbench for ttl_cache_table_core: directed and random command
// traffic with an in-bench prediction of the TTL table, and randomly stalled channels.
// Depends on ttlc_pkg, ttlc_in_if, ttlc_out_if and the ttl_cache_table_core RTL.
module ttl_cache_table_core_tb;
    import ttlc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_cmd             command;
        logic [KEY_W-1:0] key;
    } t_request;

    typedef struct packed {
        logic             hit;
        logic             inserted;
        logic             dropped_full;
        logic [OCC_W-1:0] occupancy;
        logic [OCC_W-1:0] peak_occupancy;
    } t_outcome;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    ttlc_in_if  req_if ();
    ttlc_out_if rsp_if ();

    ttl_cache_table_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    // Commands waiting to be sent and results waiting to come back
    t_request cmd_backlog[$];
    t_outcome due_results[$];

    // Predicted table contents and registers
    logic [KEY_W-1:0]    slot_key    [CAPACITY];
    logic [TIME_W-1:0]   slot_expiry [CAPACITY];
    logic [CAPACITY-1:0] slot_live   = '0;
    logic [TIME_W-1:0]   now_ticks   = '0;
    logic [PERIOD_W-1:0] sweep_cnt   = '0;
    logic [OCC_W-1:0]    held        = '0;
    logic [OCC_W-1:0]    peak        = '0;
    logic [TTL_W-1:0]    ttl_reg     = TTL_W'(TTL_RESET);
    logic [PERIOD_W-1:0] period_reg  = PERIOD_W'(PERIOD_RESET);

    // Run statistics and control
    int  fails        = 0;
    int  beats_in     = 0;
    int  hits         = 0;
    int  inserts      = 0;
    int  drops        = 0;
    int  stale_misses = 0;
    int  swept        = 0;
    bit  calm         = 1'b0;
    int  send_gap     = 0;
    int  stall        = 0;
    logic [KEY_W-1:0] key_pool [128];

    // Expired when (now - expiry) mod 2^32 is positive as a signed value
    function automatic bit lapsed(logic [TIME_W-1:0] expiry);
        logic [TIME_W-1:0] d;
        d = now_ticks - expiry;
        return (d != '0) && !d[TIME_W-1];
    endfunction

    function automatic int find_slot(logic [KEY_W-1:0] key);
        for (int i = 0; i < CAPACITY; i++) begin
            if (slot_live[i] && slot_key[i] == key)
                return i;
        end
        return -1;
    endfunction

    // Apply one command to the predicted table and return its result beat
    function automatic t_outcome cache_outcome(t_cmd cmd, logic [KEY_W-1:0] key);
        t_outcome res;
        int       slot;
        res  = '0;
        slot = -1;
        case (cmd)
            CMD_TICK: begin
                now_ticks = now_ticks + 1;
                sweep_cnt = sweep_cnt + PERIOD_W'(1);
                // a zero period compares as always reached
                if (sweep_cnt >= period_reg) begin
                    sweep_cnt = '0;
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (slot_live[i] && lapsed(slot_expiry[i])) begin
                            slot_live[i] = 1'b0;
                            held = held - OCC_W'(1);
                            swept++;
                        end
                    end
                end
            end
            CMD_LOOKUP: begin
                slot = find_slot(key);
                if (slot >= 0) begin
                    if (lapsed(slot_expiry[slot])) begin
                        slot_live[slot] = 1'b0;
                        held = held - OCC_W'(1);
                        stale_misses++;
                    end else begin
                        slot_expiry[slot] = now_ticks + TIME_W'(ttl_reg);
                        res.hit = 1'b1;
                        hits++;
                    end
                end
            end
            CMD_STORE: begin
                // a present key, even an expired one, is left alone
                if (find_slot(key) < 0) begin
                    for (int i = CAPACITY - 1; i >= 0; i--) begin
                        if (!slot_live[i])
                            slot = i;
                    end
                    if (slot < 0) begin
                        res.dropped_full = 1'b1;
                        drops++;
                    end else begin
                        slot_live[slot]   = 1'b1;
                        slot_key[slot]    = key;
                        slot_expiry[slot] = now_ticks + TIME_W'(ttl_reg);
                        held = held + OCC_W'(1);
                        if (held > peak)
                            peak = held;
                        res.inserted = 1'b1;
                        inserts++;
                    end
                end
            end
            default: begin
                slot_live = '0;
                held      = '0;
            end
        endcase
        res.occupancy      = held;
        res.peak_occupancy = peak;
        return res;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Command driver; each accepted beat is predicted on the edge that takes it
    always @(posedge i_clk) begin : cmd_driver
        t_request item;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            send_gap     <= 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                due_results.push_back(cache_outcome(t_cmd'(req_if.command), req_if.key));
                beats_in++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (send_gap != 0) begin
                    req_if.valid <= 1'b0;
                    send_gap     <= send_gap - 1;
                end else if (cmd_backlog.size() != 0) begin
                    item = cmd_backlog.pop_front();
                    req_if.valid   <= 1'b1;
                    req_if.command <= item.command;
                    req_if.key     <= item.key;
                    if (!calm && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 14);
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random stalls on ready
    always @(posedge i_clk) begin : result_check
        t_outcome want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            stall        <= 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (due_results.size() == 0) begin
                    $error("result beat with no command outstanding");
                    fails++;
                end else begin
                    want = due_results.pop_front();
                    check_field("hit", 32'(want.hit), 32'(rsp_if.hit));
                    check_field("inserted", 32'(want.inserted), 32'(rsp_if.inserted));
                    check_field("dropped_full", 32'(want.dropped_full),
                                32'(rsp_if.dropped_full));
                    check_field("occupancy", 32'(want.occupancy), 32'(rsp_if.occupancy));
                    check_field("peak_occupancy", 32'(want.peak_occupancy),
                                32'(rsp_if.peak_occupancy));
                end
            end
            if (stall != 0) begin
                rsp_if.ready <= 1'b0;
                stall        <= stall - 1;
            end else begin
                rsp_if.ready <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0)
                    stall <= $urandom_range(1, 14);
            end
        end
    end

    task automatic push_cmd(t_cmd cmd, logic [KEY_W-1:0] key);
        t_request item;
        item.command = cmd;
        item.key     = key;
        cmd_backlog.push_back(item);
    endtask

    // Wait until nothing is queued, in flight or owed, then let the pipeline settle
    task automatic wait_idle();
        do @(negedge i_clk);
        while (cmd_backlog.size() != 0 || req_if.valid || due_results.size() != 0);
        repeat (6) @(posedge i_clk);
    endtask

    // Write both registers while idle; the period write carries junk above bit 15
    task automatic set_regs(logic [TTL_W-1:0] ttl, logic [PERIOD_W-1:0] period);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_TTL;
        cfg_data <= CFG_DATA_W'(ttl);
        @(posedge i_clk);
        ttl_reg  = ttl;
        cfg_idx  <= CFG_PERIOD;
        cfg_data <= {4'($urandom), period};
        @(posedge i_clk);
        period_reg = period;
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] pick_key(int pool_n);
        if ($urandom_range(0, 99) < 15)
            return $urandom;
        return key_pool[$urandom_range(0, pool_n - 1)];
    endfunction

    // One random phase: keys mostly from a small pool so hits and expiries happen
    task automatic run_phase(logic [TTL_W-1:0] ttl, logic [PERIOD_W-1:0] period,
                             int count, int pool_n, int tick_w, int look_w, int store_w);
        int   r;
        t_cmd cmd;
        set_regs(ttl, period);
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < tick_w)
                cmd = CMD_TICK;
            else if (r < tick_w + look_w)
                cmd = CMD_LOOKUP;
            else if (r < tick_w + look_w + store_w)
                cmd = CMD_STORE;
            else
                cmd = CMD_FLUSH;
            push_cmd(cmd, pick_key(pool_n));
        end
    endtask

    // Stimulus
    initial begin
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = CFG_TTL;
        cfg_data       = '0;
        req_if.valid   = 1'b0;
        req_if.command = CMD_TICK;
        req_if.key     = '0;
        rsp_if.ready   = 1'b0;
        foreach (key_pool[i])
            key_pool[i] = $urandom;
        key_pool[0] = '0;
        key_pool[1] = '1;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extreme keys, every command, renewal on hit, duplicate store
        push_cmd(CMD_STORE,  32'h0000_0000);
        push_cmd(CMD_STORE,  32'hFFFF_FFFF);
        push_cmd(CMD_STORE,  32'h0000_0000);
        push_cmd(CMD_LOOKUP, 32'h0000_0000);
        push_cmd(CMD_LOOKUP, 32'hFFFF_FFFF);
        push_cmd(CMD_LOOKUP, 32'h1234_5678);
        push_cmd(CMD_TICK,   32'hDEAD_BEEF);
        push_cmd(CMD_FLUSH,  32'hFFFF_FFFF);
        push_cmd(CMD_LOOKUP, 32'h0000_0000);
        push_cmd(CMD_STORE,  32'hA5A5_A5A5);

        // Zero ttl and zero period: entry expires on the next tick and is swept
        set_regs(20'd0, 16'd0);
        push_cmd(CMD_STORE,  32'h0000_0001);
        push_cmd(CMD_LOOKUP, 32'h0000_0001);
        push_cmd(CMD_TICK,   32'h0);
        push_cmd(CMD_LOOKUP, 32'h0000_0001);

        // Long period: expired entry survives until a lookup removes it
        set_regs(20'd2, 16'hFFFF);
        push_cmd(CMD_STORE,  32'h0000_0002);
        push_cmd(CMD_TICK,   32'h0);
        push_cmd(CMD_TICK,   32'h0);
        push_cmd(CMD_TICK,   32'h0);
        push_cmd(CMD_STORE,  32'h0000_0002);
        push_cmd(CMD_LOOKUP, 32'h0000_0002);
        push_cmd(CMD_STORE,  32'h0000_0002);

        // Random phases over a spread of settings; the first fills the table
        run_phase(20'd1000000, 16'hFFFF, 200, 100,  5, 30, 64);
        run_phase(20'd0,       16'd0,    120,  16, 30, 35, 30);
        run_phase(20'd3,       16'hFFFF, 150,  20, 35, 35, 28);
        run_phase(20'd1,       16'd1,    100,  12, 30, 35, 30);
        run_phase(20'd20,      16'd7,    200,  80, 20, 30, 48);
        run_phase(TTL_W'(TTL_RESET), 16'd2, 130, 40, 30, 30, 36);
        wait_idle();
        calm = 1'b1;
        run_phase(20'd5,       16'd3,    120,  70, 25, 30, 44);

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (due_results.size() != 0) begin
            $error("%0d results never arrived", due_results.size());
            fails++;
        end
        $display("Ran %0d commands: %0d hits, %0d inserts, %0d stores dropped on a full table",
                 beats_in, hits, inserts, drops);
        $display("Expired entries removed: %0d by lookup, %0d by sweep; peak occupancy %0d",
                 stale_misses, swept, peak);
        if (fails == 0)
            $display("ttl_cache_table_core test passed");
        else
            $display("ttl_cache_table_core test failed");
        $finish;
    end

    // Watchdog
    initial begin
        #3_000_000;
        $display("ttl_cache_table_core test failed");
        $finish;
    end

endmodule
